### hw/rtl/ppbs_pkg.sv
// ppbs_pkg: shared types, constants and the per-channel average for the palette pixel blend stream
// no dependencies; imported by every module of the block

package ppbs_pkg;

    localparam int unsigned CIDX_W     = 15;
    localparam int unsigned ECOL_W     = 30;
    localparam int unsigned PIX_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;

    localparam int unsigned OUT_DEPTH  = 4;
    localparam int unsigned OPW        = $clog2(OUT_DEPTH);
    localparam int unsigned OCW        = $clog2(OUT_DEPTH + 1);

    localparam logic [PIX_W-1:0] MASK_24 = 32'h0101_0101;
    localparam logic [PIX_W-1:0] MASK_30 = 32'h4010_0401;

    localparam logic MODE_PIXEL = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_DEPTH  = 3'd0,
        CFG_BLEND_EN     = 3'd1,
        CFG_BLEED_EN     = 3'd2,
        CFG_FRAME_WIDTH  = 3'd3,
        CFG_FRAME_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic              valid;
        logic              write;
        logic [CIDX_W-1:0] color_index;
        logic [ECOL_W-1:0] entry_color;
    } t_pal_req;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_color;
        logic             line_end;
        logic             frame_end;
    } t_result;

    function automatic logic [PIX_W-1:0] chan_avg(
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b,
        input logic             wide
    );
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] s;
        m = wide ? MASK_30 : MASK_24;
        s = a + b;
        s = s - ((a ^ b) & m);
        return {1'b0, s[PIX_W-1:1]};
    endfunction

endpackage

### hw/rtl/palette_pixel_blend_stream.sv
// palette_pixel_blend_stream: top level with counters, config, blend and bleed stages
// uses ppbs_pkg, ppbs_palette, ppbs_frame_store and ppbs_out_fifo
//
// Input requests carry either a palette write (mode 0) or one raster-order pixel index
// (mode 1). A request is taken when i_valid is high and o_stall is low; results leave
// when o_valid is high and i_stall is low. Config writes use i_cfg_valid/o_cfg_ready,
// and o_cfg_ready is always high; write config only while the block is idle.
// One request per cycle is taken in steady state while o_stall is low. A pixel without
// color bleed runs through stages s1 to s4; with bleed on, a pixel that is not last in
// its line waits for its right neighbour and comes out just ahead of that neighbour's
// result. The last pixel of a line with bleed gives two results in one cycle.
// Throughput is set by the single read per pixel of the palette memory and the frame
// store banks, and by the four-entry result queue: o_stall rises when the queue holds
// more than two results. Frames of only a few pixels re-read an entry still being
// written, and the interlock holds such a pixel while a clashing one is in s1 to s3.
// Reset (and a change of frame size) marks the frame store stale: the next frame reads
// zeros instead of stored pixels, so no clearing pass is needed and requests are taken
// right after reset. When the receiver stalls, results collect in the queue and the
// pipeline halts as a whole once the queue is close to full.

module palette_pixel_blend_stream #(
    parameter int unsigned PALETTE_ENTRIES = 32768,
    parameter int unsigned MAX_WIDTH       = 512,
    parameter int unsigned MAX_HEIGHT      = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_mode,
    input  logic [ppbs_pkg::CIDX_W-1:0]       i_color_index,
    input  logic [ppbs_pkg::ECOL_W-1:0]       i_entry_color,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [ppbs_pkg::PIX_W-1:0]        o_pixel_color,
    output logic                              o_line_end,
    output logic                              o_frame_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ppbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ppbs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ppbs_pkg::*;

    localparam int unsigned CW     = $clog2(MAX_WIDTH);
    localparam int unsigned CW1    = CW + 1;
    localparam int unsigned RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned RW1    = RW + 1;
    localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned HALF   = (MAX_WIDTH + 1) / 2;
    localparam int unsigned BDEPTH = HALF * MAX_HEIGHT;
    localparam int unsigned BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int unsigned W_RST  = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
    localparam int unsigned H_RST  = (224 > MAX_HEIGHT) ? MAX_HEIGHT : 224;

    typedef struct packed {
        logic           valid;
        logic [RW-1:0]  row;
        logic [CW-1:0]  col;
        logic           col0;
        logic           col_nz;
        logic [BAW-1:0] baddr;
        logic           last_col;
        logic           last_row;
        logic           fresh;
    } t_stage;

    // config
    logic          r_depth30;
    logic          r_blend;
    logic          r_bleed;
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;

    // raster position and frame store epoch
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_fresh;

    logic             r_held_valid;
    logic [PIX_W-1:0] r_held;

    t_stage r_s1, r_s2, r_s3, r_s4;
    t_stage n_s1;
    logic [PIX_W-1:0] r_s4_color;
    logic [PIX_W-1:0] n_color;

    logic w_en;
    logic w_hazard;
    logic w_accept;
    logic w_pix_accept;
    logic w_last_col;
    logic w_last_row;
    logic [CW1-1:0] w_col_p1;
    logic [RW1-1:0] w_row_p1;
    logic [31:0]    w_row_base;

    logic [WW-1:0] n_width;
    logic [HW-1:0] n_height;
    logic          w_cfg_wr;

    t_pal_req          w_pal_req;
    logic [ECOL_W-1:0] w_pal_color;

    logic [1:0]       w_fs_we;
    logic [BAW-1:0]   w_fs_waddr [2];
    logic [PIX_W-1:0] w_fs_wdata [2];
    logic [PIX_W-1:0] w_fs_rdata [2];
    logic [PIX_W-1:0] w_prev;
    logic [PIX_W-1:0] w_pal_ext;

    logic             w_bleed_out;
    logic             w_direct;
    logic [PIX_W-1:0] w_bleed_color;
    logic [1:0]       w_wr_cnt;
    t_result          w_res [2];
    t_result          w_out;

    function automatic logic conflict(input t_stage s, input logic [RW-1:0] row,
                                      input logic [CW-1:0] col, input logic [CW1-1:0] col_p1);
        return s.valid && (s.row == row) && ((s.col == col) || (CW1'(s.col) == col_p1));
    endfunction

    // frame store interlock against pixels whose writes are still ahead
    assign w_col_p1 = CW1'(r_col) + CW1'(1);
    assign w_row_p1 = RW1'(r_row) + RW1'(1);
    assign w_hazard = conflict(r_s1, r_row, r_col, w_col_p1)
                   || conflict(r_s2, r_row, r_col, w_col_p1)
                   || conflict(r_s3, r_row, r_col, w_col_p1);

    assign o_stall      = !w_en || w_hazard;
    assign w_accept     = i_valid && !o_stall;
    assign w_pix_accept = w_accept && (i_mode == MODE_PIXEL);
    assign w_last_col   = (w_col_p1 >= CW1'(r_width));
    assign w_last_row   = (w_row_p1 >= RW1'(r_height));
    assign w_row_base   = 32'(r_row) * 32'(HALF);

    always_comb begin
        n_s1.valid    = w_pix_accept;
        n_s1.row      = r_row;
        n_s1.col      = r_col;
        n_s1.col0     = r_col[0];
        n_s1.col_nz   = (r_col != '0);
        n_s1.baddr    = BAW'(w_row_base) + BAW'(r_col >> 1);
        n_s1.last_col = w_last_col;
        n_s1.last_row = w_last_row;
        n_s1.fresh    = r_fresh;
    end

    assign w_pal_req.valid       = w_accept;
    assign w_pal_req.write       = (i_mode != MODE_PIXEL);
    assign w_pal_req.color_index = i_color_index;
    assign w_pal_req.entry_color = i_entry_color;

    ppbs_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_req   (w_pal_req),
        .o_color (w_pal_color)
    );

    ppbs_frame_store #(
        .DEPTH (BDEPTH),
        .AW    (BAW)
    ) u_frame_store (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_raddr (r_s2.baddr),
        .i_we    (w_fs_we),
        .i_waddr (w_fs_waddr),
        .i_wdata (w_fs_wdata),
        .o_rdata (w_fs_rdata)
    );

    // blend with the previous frame
    assign w_pal_ext = PIX_W'(w_pal_color);
    assign w_prev    = r_s3.fresh ? '0 : w_fs_rdata[r_s3.col0];
    assign n_color   = r_blend ? chan_avg(w_prev, w_pal_ext, r_depth30) : w_pal_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            r_s4.valid <= 1'b0;
        end else if (w_en) begin
            r_s1       <= n_s1;
            r_s2       <= r_s1;
            r_s3       <= r_s2;
            r_s4       <= r_s3;
            r_s4_color <= n_color;
        end
    end

    // color bleed and result assembly
    assign w_bleed_out   = r_s4.valid && r_held_valid && r_s4.col_nz;
    assign w_direct      = r_s4.valid && !(r_bleed && !r_s4.last_col);
    assign w_bleed_color = chan_avg(r_held, r_s4_color, r_depth30);

    always_comb begin
        w_res[0].pixel_color = w_bleed_color;
        w_res[0].line_end    = 1'b0;
        w_res[0].frame_end   = 1'b0;
        w_res[1].pixel_color = r_s4_color;
        w_res[1].line_end    = r_s4.last_col;
        w_res[1].frame_end   = r_s4.last_col && r_s4.last_row;
        if (!w_bleed_out) begin
            w_res[0] = w_res[1];
        end
        w_wr_cnt = 2'(w_bleed_out) + 2'(w_direct);
        if (!w_en) begin
            w_wr_cnt = 2'd0;
        end
    end

    // direct write goes to the pixel's own bank, the bleed write to its left neighbour
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            if (w_direct && (r_s4.col0 == 1'(b))) begin
                w_fs_we[b]    = w_en;
                w_fs_waddr[b] = r_s4.baddr;
                w_fs_wdata[b] = r_s4_color;
            end else begin
                w_fs_we[b]    = w_en && w_bleed_out && (r_s4.col0 != 1'(b));
                w_fs_waddr[b] = r_s4.col0 ? r_s4.baddr : (r_s4.baddr - BAW'(1));
                w_fs_wdata[b] = w_bleed_color;
            end
        end
    end

    ppbs_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_cnt   (w_wr_cnt),
        .i_wr_data  (w_res),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (w_out),
        .o_space_ok (w_en)
    );

    assign o_pixel_color = w_out.pixel_color;
    assign o_line_end    = w_out.line_end;
    assign o_frame_end   = w_out.frame_end;

    // config writes
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_width  = WW'(1);
            n_height = HW'(1);
        end else begin
            n_width  = (32'(i_cfg_data) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(i_cfg_data);
            n_height = (32'(i_cfg_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth30    <= 1'b0;
            r_blend      <= 1'b0;
            r_bleed      <= 1'b0;
            r_width      <= WW'(W_RST);
            r_height     <= HW'(H_RST);
            r_col        <= '0;
            r_row        <= '0;
            r_fresh      <= 1'b1;
            r_held_valid <= 1'b0;
        end else begin
            if (w_pix_accept) begin
                if (w_last_col) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : RW'(w_row_p1);
                    if (w_last_row) begin
                        r_fresh <= 1'b0;
                    end
                end else begin
                    r_col <= CW'(w_col_p1);
                end
            end
            if (w_en && r_s4.valid) begin
                r_held_valid <= r_bleed && !r_s4.last_col;
                r_held       <= r_s4_color;
            end
            if (w_cfg_wr) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_COLOR_DEPTH: begin
                        r_depth30 <= i_cfg_data[0];
                    end
                    CFG_BLEND_EN: begin
                        r_blend <= i_cfg_data[0];
                    end
                    CFG_BLEED_EN: begin
                        r_bleed <= i_cfg_data[0];
                    end
                    CFG_FRAME_WIDTH: begin
                        if (n_width != r_width) begin
                            r_width      <= n_width;
                            r_col        <= '0;
                            r_row        <= '0;
                            r_fresh      <= 1'b1;
                            r_held_valid <= 1'b0;
                        end
                    end
                    CFG_FRAME_HEIGHT: begin
                        if (n_height != r_height) begin
                            r_height     <= n_height;
                            r_col        <= '0;
                            r_row        <= '0;
                            r_fresh      <= 1'b1;
                            r_held_valid <= 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### hw/rtl/ppbs_palette.sv
// ppbs_palette: index reduction to the palette depth and the palette memory
// uses ppbs_pkg; requests pass stages s1 and s2, then the registered read

module ppbs_palette #(
    parameter int unsigned PALETTE_ENTRIES = 32768
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  ppbs_pkg::t_pal_req           i_req,
    output logic [ppbs_pkg::ECOL_W-1:0]  o_color
);
    import ppbs_pkg::*;

    localparam int unsigned PAW   = $clog2(PALETTE_ENTRIES);
    localparam bit          WRAP  = (PALETTE_ENTRIES < (2 ** CIDX_W));
    localparam int unsigned RECIP = WRAP ? ((2 ** CIDX_W) / PALETTE_ENTRIES) : 1;
    localparam logic [2*CIDX_W-1:0] RECIP_V = (2*CIDX_W)'(RECIP);
    localparam logic [31:0]         PMOD32  = 32'(PALETTE_ENTRIES);
    localparam logic [CIDX_W:0]     PMOD    = (CIDX_W+1)'(PALETTE_ENTRIES);

    logic              r_s1_wr;
    logic [CIDX_W-1:0] r_s1_idx;
    logic [CIDX_W-1:0] r_s1_q;
    logic [ECOL_W-1:0] r_s1_entry;

    logic              r_s2_wr;
    logic [PAW-1:0]    r_s2_idx;
    logic [ECOL_W-1:0] r_s2_entry;

    logic [ECOL_W-1:0] r_mem [PALETTE_ENTRIES];
    logic [ECOL_W-1:0] r_rdata;

    logic [2*CIDX_W-1:0] w_prod;
    logic [31:0]         w_qp;
    logic [CIDX_W:0]     w_rem;
    logic [PAW-1:0]      n_s2_idx;

    // quotient estimate, low by at most one
    assign w_prod = (2*CIDX_W)'(i_req.color_index) * RECIP_V;

    always_comb begin
        w_qp  = 32'(r_s1_q) * PMOD32;
        w_rem = (CIDX_W+1)'(r_s1_idx) - w_qp[CIDX_W:0];
        if (w_rem >= PMOD) begin
            w_rem = w_rem - PMOD;
        end
        n_s2_idx = WRAP ? PAW'(w_rem) : PAW'(r_s1_idx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_wr <= 1'b0;
            r_s2_wr <= 1'b0;
        end else if (i_en) begin
            r_s1_wr    <= i_req.valid && i_req.write;
            r_s1_idx   <= i_req.color_index;
            r_s1_q     <= w_prod[2*CIDX_W-1:CIDX_W];
            r_s1_entry <= i_req.entry_color;
            r_s2_wr    <= r_s1_wr;
            r_s2_idx   <= n_s2_idx;
            r_s2_entry <= r_s1_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_s2_wr) begin
                r_mem[r_s2_idx] <= r_s2_entry;
            end
            r_rdata <= r_mem[r_s2_idx];
        end
    end

    assign o_color = r_rdata;

endmodule

### hw/rtl/ppbs_frame_store.sv
// ppbs_frame_store: previous-frame pixel store, split into even and odd column banks
// uses ppbs_pkg; one read and one write port per bank, registered read data

module ppbs_frame_store #(
    parameter int unsigned DEPTH = 131072,
    parameter int unsigned AW    = 17
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [AW-1:0]               i_raddr,
    input  logic [1:0]                  i_we,
    input  logic [AW-1:0]               i_waddr [2],
    input  logic [ppbs_pkg::PIX_W-1:0]  i_wdata [2],
    output logic [ppbs_pkg::PIX_W-1:0]  o_rdata [2]
);
    import ppbs_pkg::*;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        logic [PIX_W-1:0] r_mem [DEPTH];
        logic [PIX_W-1:0] r_rdata;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (i_we[b]) begin
                    r_mem[i_waddr[b]] <= i_wdata[b];
                end
                r_rdata <= r_mem[i_raddr];
            end
        end

        assign o_rdata[b] = r_rdata;
    end

endmodule

### hw/rtl/ppbs_out_fifo.sv
// ppbs_out_fifo: small result queue taking up to two results a cycle, one out a cycle while i_stall is low
// uses ppbs_pkg; decouples the pipeline from the receiver's stall

module ppbs_out_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_wr_cnt,
    input  ppbs_pkg::t_result     i_wr_data [2],
    output logic                  o_valid,
    input  logic                  i_stall,
    output ppbs_pkg::t_result     o_data,
    output logic                  o_space_ok
);
    import ppbs_pkg::*;

    t_result          r_mem [OUT_DEPTH];
    logic [OPW-1:0]   r_wp;
    logic [OPW-1:0]   r_rp;
    logic [OCW-1:0]   r_count;
    logic             w_pop;
    logic [OCW-1:0]   n_count;

    assign o_valid    = (r_count != '0);
    assign w_pop      = o_valid && !i_stall;
    assign o_data     = r_mem[r_rp];
    assign o_space_ok = (r_count <= OCW'(OUT_DEPTH - 2));
    assign n_count    = r_count + OCW'(i_wr_cnt) - OCW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + OPW'(i_wr_cnt);
            r_rp    <= r_rp + OPW'(w_pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_cnt != 2'd0) begin
            r_mem[r_wp] <= i_wr_data[0];
        end
        if (i_wr_cnt == 2'd2) begin
            r_mem[r_wp + OPW'(1)] <= i_wr_data[1];
        end
    end

endmodule
